>>> design/dlcg_pkg.sv
// Shared constants, types and register codes for the distance-to-colour ring painter.
package dlcg_pkg;

   localparam int MAX_RING_LEDS = 64;
   localparam int PER_DIR_W     = $clog2(MAX_RING_LEDS / 4) + 1;
   localparam int PIX_CNT_W     = $clog2(MAX_RING_LEDS / 4);

   localparam logic [15:0] SAFE_RESET = 16'd820;
   localparam logic [15:0] WARN_RESET = 16'd200;
   localparam logic [6:0]  RING_RESET = 7'd16;
   localparam logic [6:0]  RING_MIN   = 7'd4;
   localparam logic [6:0]  RING_MAX   = 7'(MAX_RING_LEDS);

   localparam logic [1:0] REG_SAFE = 2'd0;
   localparam logic [1:0] REG_WARN = 2'd1;
   localparam logic [1:0] REG_RING = 2'd2;

   localparam int DANGER_ONE  = 65536;
   localparam int BOUND_1     = 21823;
   localparam int BOUND_2     = 43647;
   localparam int SPAN_2      = BOUND_2 - BOUND_1;
   localparam int SPAN_3      = DANGER_ONE - BOUND_2;
   localparam int FULL_SCALE  = 255;
   localparam int GREEN_DROP  = 115;
   localparam int ORANGE_GRN  = 140;
   localparam logic [7:0] FAR_GREEN = 8'd40;

   localparam int DIV_STEPS    = 16;
   localparam int COLOUR_STEPS = 1;

   // reciprocals of the segment spans, exact for numerators below 2**23
   localparam int     RECIP_SHIFT = 38;
   localparam longint RECIP_1 = ((longint'(1) << RECIP_SHIFT) + BOUND_1 - 1) / BOUND_1;
   localparam longint RECIP_2 = ((longint'(1) << RECIP_SHIFT) + SPAN_2 - 1) / SPAN_2;
   localparam longint RECIP_3 = ((longint'(1) << RECIP_SHIFT) + SPAN_3 - 1) / SPAN_3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [1:0] dir;
      logic [7:0] red;
      logic [7:0] green;
   } word_type;

   typedef struct packed {
      logic [1:0]  dir;
      logic        far;
      logic        near;
      logic [15:0] rem;
      logic [15:0] den;
      logic [15:0] quo;
   } danger_stage_type;

   typedef struct packed {
      logic [1:0]  dir;
      logic        far;
      logic        seg1;
      logic [22:0] num;
      logic [23:0] recip;
      logic [7:0]  quo;
   } colour_stage_type;

endpackage

>>> design/distance_to_led_color_gradient.sv
// Top level of the distance-to-colour ring painter: registers, front end, queue, sequencer.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_direction, req_distance_mm
//   rsp      out        rsp_valid/rsp_ready    rsp_pixel_index, rsp_red, rsp_green,
//                                              rsp_blue, rsp_last_pixel
//   csr      in         csr_we                 csr_index, csr_wdata
//
// Each nonzero distance word gives a quarter of the ring's LEDs in rsp words (1 to 16), one
// per cycle while rsp_ready holds; that pixel loop in the sequencer sets the sustained rate,
// a zero distance costs no rsp slot.
// The front end is a 19-stage pipeline: an input register, 16 danger divide steps, a colour
// segment setup and a colour reciprocal multiply.
// Synchronous active-high reset clears valid state and loads 820 / 200 / 16 into the registers.
// A stalled rsp backs up the sequencer, then the 4-word queue, then req_ready.
module distance_to_led_color_gradient (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_direction,
   input  logic [15:0] req_distance_mm,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_pixel_index,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_last_pixel,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [15:0]        safe_ff, warn_ff;
   logic [6:0]         leds_ff;
   logic               ring_ok;
   logic               word_valid, word_ready;
   dlcg_pkg::word_type word;
   logic               q_valid, q_ready;
   dlcg_pkg::word_type q_word;

   assign ring_ok = (csr_wdata[6:0] >= dlcg_pkg::RING_MIN) &&
                    (csr_wdata[6:0] <= dlcg_pkg::RING_MAX);

   always_ff @(posedge clock) begin
      if (reset) begin
         safe_ff <= dlcg_pkg::SAFE_RESET;
         warn_ff <= dlcg_pkg::WARN_RESET;
         leds_ff <= dlcg_pkg::RING_RESET;
      end else if (csr_we) begin
         case (csr_index)
            dlcg_pkg::REG_SAFE: begin
               safe_ff <= csr_wdata;
            end
            dlcg_pkg::REG_WARN: begin
               warn_ff <= csr_wdata;
            end
            dlcg_pkg::REG_RING: begin
               if (ring_ok) begin
                  leds_ff <= csr_wdata[6:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   dlcg_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_direction     (req_direction),
      .req_distance_mm   (req_distance_mm),
      .safe_threshold    (safe_ff),
      .warning_threshold (warn_ff),
      .word_valid        (word_valid),
      .word_ready        (word_ready),
      .word              (word)
   );

   dlcg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (word_valid),
      .in_ready  (word_ready),
      .in_word   (word),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_word  (q_word)
   );

   dlcg_back u_back (
      .clock           (clock),
      .reset           (reset),
      .word_valid      (q_valid),
      .word_ready      (q_ready),
      .word            (q_word),
      .ring_size       (leds_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_last_pixel  (rsp_last_pixel)
   );

   a_reset_quiet: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high right after reset");

   a_ring_range: assert property (@(posedge clock) disable iff (reset)
      leds_ff >= dlcg_pkg::RING_MIN && leds_ff <= dlcg_pkg::RING_MAX)
      else $error("ring led count out of range");

   a_ring_guard: assert property (@(posedge clock) disable iff (reset)
      csr_we && csr_index == dlcg_pkg::REG_RING &&
      (csr_wdata[6:0] < dlcg_pkg::RING_MIN || csr_wdata[6:0] > dlcg_pkg::RING_MAX)
      |=> $stable(leds_ff))
      else $error("illegal ring led count was taken");

   a_front_stall: assert property (@(posedge clock) disable iff (reset)
      word_valid && !word_ready |-> !req_ready)
      else $error("front end accepts while its output is blocked");

endmodule

>>> design/dlcg_front.sv
// Front end: accepts distance words, classifies them, runs the danger divider and colour scaling.
module dlcg_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_direction,
   input  logic [15:0]         req_distance_mm,
   input  logic [15:0]         safe_threshold,
   input  logic [15:0]         warning_threshold,
   output logic                word_valid,
   input  logic                word_ready,
   output dlcg_pkg::word_type  word
);

   function automatic dlcg_pkg::danger_stage_type dstep(input dlcg_pkg::danger_stage_type s);
      dlcg_pkg::danger_stage_type o;
      logic [16:0] r;
      logic [16:0] diff;
      o    = s;
      r    = {s.rem, 1'b0};
      diff = r - {1'b0, s.den};
      if (r >= {1'b0, s.den}) begin
         o.rem = diff[15:0];
         o.quo = {s.quo[14:0], 1'b1};
      end else begin
         o.rem = r[15:0];
         o.quo = {s.quo[14:0], 1'b0};
      end
      return o;
   endfunction

   function automatic dlcg_pkg::colour_stage_type cinit(input dlcg_pkg::danger_stage_type s);
      dlcg_pkg::colour_stage_type o;
      logic [16:0] danger;
      logic [22:0] num;
      danger = s.near ? 17'(dlcg_pkg::DANGER_ONE) : {1'b0, s.quo};
      o.dir  = s.dir;
      o.far  = s.far;
      o.seg1 = 1'b0;
      o.quo  = '0;
      if (danger <= 17'(dlcg_pkg::BOUND_1)) begin
         o.seg1  = 1'b1;
         num     = 23'(danger) * 23'(dlcg_pkg::FULL_SCALE);
         o.recip = 24'(dlcg_pkg::RECIP_1);
      end else if (danger <= 17'(dlcg_pkg::BOUND_2)) begin
         num     = 23'(dlcg_pkg::FULL_SCALE * dlcg_pkg::SPAN_2)
                   - 23'(danger - 17'(dlcg_pkg::BOUND_1)) * 23'(dlcg_pkg::GREEN_DROP);
         o.recip = 24'(dlcg_pkg::RECIP_2);
      end else begin
         num     = 23'(17'(dlcg_pkg::DANGER_ONE) - danger) * 23'(dlcg_pkg::ORANGE_GRN);
         o.recip = 24'(dlcg_pkg::RECIP_3);
      end
      o.num = num;
      return o;
   endfunction

   function automatic dlcg_pkg::colour_stage_type cstep(input dlcg_pkg::colour_stage_type s);
      dlcg_pkg::colour_stage_type o;
      logic [46:0] prod;
      o     = s;
      prod  = 47'(s.num) * 47'(s.recip);
      o.quo = prod[dlcg_pkg::RECIP_SHIFT+7:dlcg_pkg::RECIP_SHIFT];
      return o;
   endfunction

   logic                               advance;
   logic [dlcg_pkg::DIV_STEPS:0]       dv_ff, dv_in;
   logic [dlcg_pkg::COLOUR_STEPS:0]    cv_ff, cv_in;
   dlcg_pkg::danger_stage_type         ds_ff [0:dlcg_pkg::DIV_STEPS];
   dlcg_pkg::danger_stage_type         ds_in [0:dlcg_pkg::DIV_STEPS];
   dlcg_pkg::colour_stage_type         cs_ff [0:dlcg_pkg::COLOUR_STEPS];
   dlcg_pkg::colour_stage_type         cs_in [0:dlcg_pkg::COLOUR_STEPS];

   assign advance    = !(cv_ff[dlcg_pkg::COLOUR_STEPS] && !word_ready);
   assign req_ready  = advance;
   assign word_valid = cv_ff[dlcg_pkg::COLOUR_STEPS];

   always_comb begin
      dv_in[0]      = req_valid && (req_distance_mm != 16'd0);
      ds_in[0].dir  = req_direction;
      ds_in[0].far  = req_distance_mm >= safe_threshold;
      ds_in[0].near = req_distance_mm <= warning_threshold;
      ds_in[0].rem  = safe_threshold - req_distance_mm;
      ds_in[0].den  = safe_threshold - warning_threshold;
      ds_in[0].quo  = '0;
      for (int k = 0; k < dlcg_pkg::DIV_STEPS; k++) begin
         ds_in[k+1] = dstep(ds_ff[k]);
         dv_in[k+1] = dv_ff[k];
      end
      cs_in[0] = cinit(ds_ff[dlcg_pkg::DIV_STEPS]);
      cv_in[0] = dv_ff[dlcg_pkg::DIV_STEPS];
      for (int k = 0; k < dlcg_pkg::COLOUR_STEPS; k++) begin
         cs_in[k+1] = cstep(cs_ff[k]);
         cv_in[k+1] = cv_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= '0;
         cv_ff <= '0;
      end else if (advance) begin
         dv_ff <= dv_in;
         cv_ff <= cv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ds_ff <= ds_in;
         cs_ff <= cs_in;
      end
   end

   always_comb begin
      word.dir = cs_ff[dlcg_pkg::COLOUR_STEPS].dir;
      if (cs_ff[dlcg_pkg::COLOUR_STEPS].far) begin
         word.red   = 8'd0;
         word.green = dlcg_pkg::FAR_GREEN;
      end else if (cs_ff[dlcg_pkg::COLOUR_STEPS].seg1) begin
         word.red   = cs_ff[dlcg_pkg::COLOUR_STEPS].quo;
         word.green = 8'(dlcg_pkg::FULL_SCALE);
      end else begin
         word.red   = 8'(dlcg_pkg::FULL_SCALE);
         word.green = cs_ff[dlcg_pkg::COLOUR_STEPS].quo;
      end
   end

endmodule

>>> design/dlcg_queue.sv
// Short queue of colour words between the front end and the pixel sequencer.
module dlcg_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  dlcg_pkg::word_type in_word,
   output logic               out_valid,
   input  logic               out_ready,
   output dlcg_pkg::word_type out_word
);

   logic [dlcg_pkg::QPTR_W:0]   count_ff, count_in;
   logic [dlcg_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [dlcg_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   dlcg_pkg::word_type          mem_ff [0:dlcg_pkg::QUEUE_DEPTH-1];
   logic                        push, pop;

   assign in_ready  = count_ff != (dlcg_pkg::QPTR_W+1)'(dlcg_pkg::QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_word  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_word;
      end
   end

endmodule

>>> design/dlcg_back.sv
// Pixel sequencer: paints one colour word onto its quarter of the ring, one pixel per cycle while rsp_ready holds.
module dlcg_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               word_valid,
   output logic               word_ready,
   input  dlcg_pkg::word_type word,
   input  logic [6:0]         ring_size,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [5:0]         rsp_pixel_index,
   output logic [7:0]         rsp_red,
   output logic [7:0]         rsp_green,
   output logic [7:0]         rsp_blue,
   output logic               rsp_last_pixel
);

   logic [dlcg_pkg::PER_DIR_W-1:0] per_dir;
   logic [dlcg_pkg::PIX_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           active_ff, active_in;
   dlcg_pkg::word_type             cur_ff;
   logic                           out_adv, emit, is_last, load;
   logic [6:0]                     start, index_sum;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [5:0]                     pix_ff;
   logic [7:0]                     red_ff, green_ff;
   logic                           last_ff;

   assign per_dir   = ring_size[6:2];
   assign out_adv   = !rsp_valid_ff || rsp_ready;
   assign emit      = active_ff && out_adv;
   assign is_last   = {1'b0, cnt_ff} == (per_dir - 1'b1);
   assign load      = word_valid && (!active_ff || (emit && is_last));
   assign word_ready = !active_ff || (emit && is_last);
   assign start     = 7'(cur_ff.dir) * 7'(per_dir);
   assign index_sum = start + 7'(cnt_ff);

   always_comb begin
      active_in = active_ff;
      cnt_in    = cnt_ff;
      if (load) begin
         active_in = 1'b1;
         cnt_in    = '0;
      end else if (emit) begin
         active_in = !is_last;
         cnt_in    = cnt_ff + 1'b1;
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= word;
      end
      if (emit) begin
         pix_ff   <= index_sum[5:0];
         red_ff   <= cur_ff.red;
         green_ff <= cur_ff.green;
         last_ff  <= is_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_index = pix_ff;
   assign rsp_red         = red_ff;
   assign rsp_green       = green_ff;
   assign rsp_blue        = 8'd0;
   assign rsp_last_pixel  = last_ff;

endmodule
